// ===== hdl/mieg_pkg.sv =====
// Shared constants, types and control structures for the modular inverse block.
package mieg_pkg;

    localparam int WIDTH   = 32;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_init;
        logic div_step;
        logic update;
        logic update_init;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic m_zero;
        logic r1_zero;
        logic div_last;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== hdl/mieg_if.sv =====
// Handshake channel interfaces for input and result items.
interface mieg_in_if;
    logic                          valid;
    logic                          ready;
    logic [mieg_pkg::FIELD_W-1:0]  value;
    logic [mieg_pkg::FIELD_W-1:0]  modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mieg_out_if;
    logic                          valid;
    logic                          ready;
    logic [mieg_pkg::FIELD_W-1:0]  divisor;
    logic [mieg_pkg::FIELD_W-1:0]  inverse_value;
    logic                          has_inverse;

    modport source (output valid, output divisor, output inverse_value, output has_inverse,
                    input ready);
    modport sink   (input valid, input divisor, input inverse_value, input has_inverse,
                    output ready);
endinterface

// ===== hdl/mieg_ctrl.sv =====
// Sequencer for the extended Euclidean datapath.
module mieg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output mieg_pkg::t_dp_cmd o_cmd,
    input  mieg_pkg::t_dp_sts i_sts
);
    import mieg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_STEP,
        S_TEST,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_init, n_init;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_init  = r_init;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.m_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_init  = 1'b1;
                    n_init          = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.update      = 1'b1;
                o_cmd.update_init = r_init;
                n_init            = 1'b0;
                n_state           = S_TEST;
            end
            S_TEST: begin
                if (i_sts.r1_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
            r_init     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
            r_init     <= n_init;
        end
    end

    assign o_ready = r_in_ready;

endmodule

// ===== hdl/mieg_dp.sv =====
// Remainder sequence, coefficient tracking and shared bit-serial divider.
module mieg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mieg_pkg::t_dp_cmd i_cmd,
    output mieg_pkg::t_dp_sts o_sts,
    input  mieg_pkg::t_field  i_value,
    input  mieg_pkg::t_field  i_modulus,
    output logic              o_valid,
    input  logic              i_ready,
    output mieg_pkg::t_field  o_divisor,
    output mieg_pkg::t_field  o_inverse_value,
    output logic              o_has_inverse
);
    import mieg_pkg::*;

    t_word r_a, r_m;
    t_word r_r0, r_r1, r_u0, r_u1;
    logic  r_s0, r_s1;

    t_word r_rem, r_quo, r_div, r_mul, r_prod;
    t_cnt  r_cnt;

    logic  r_ovalid;
    t_field r_divisor, r_inverse;
    logic  r_has_inv;

    logic [WIDTH:0] shifted, trial;
    logic           qbit;
    t_word          n_rem, n_quo, n_prod;

    t_word g, mag, inv;
    logic  ok;

    always_comb begin
        shifted = {r_rem, r_quo[WIDTH-1]};
        trial   = shifted - {1'b0, r_div};
        qbit    = !trial[WIDTH];
        n_rem   = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
        n_quo   = {r_quo[WIDTH-2:0], qbit};
        n_prod  = {r_prod[WIDTH-2:0], 1'b0} + (qbit ? r_mul : '0);
    end

    always_comb begin
        g   = (r_m == '0) ? r_a : r_r0;
        ok  = (r_m != '0) && (r_r0 == WIDTH'(1));
        mag = (r_u0 >= r_m) ? (r_u0 - r_m) : r_u0;
        if (!ok) begin
            inv = '0;
        end else if (r_s0 || (mag == '0)) begin
            inv = mag;
        end else begin
            inv = r_m - mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= WIDTH'(i_value);
            r_m <= WIDTH'(i_modulus);
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_prod <= '0;
            r_cnt  <= '0;
            r_quo  <= i_cmd.div_init ? r_a : r_r0;
            r_div  <= i_cmd.div_init ? r_m : r_r1;
            r_mul  <= i_cmd.div_init ? '0  : r_u1;
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_prod <= n_prod;
            r_cnt  <= r_cnt + t_cnt'(1);
        end
        if (i_cmd.update) begin
            if (i_cmd.update_init) begin
                r_r0 <= r_m;
                r_r1 <= r_rem;
                r_u0 <= '0;
                r_u1 <= WIDTH'(1);
                r_s0 <= 1'b1;
                r_s1 <= 1'b1;
            end else begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_u0 <= r_u1;
                r_u1 <= r_u0 + r_prod;
                r_s0 <= r_s1;
                r_s1 <= !r_s1;
            end
        end
        if (i_cmd.publish) begin
            r_divisor <= FIELD_W'(g);
            r_inverse <= FIELD_W'(inv);
            r_has_inv <= ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.m_zero   = (r_m == '0);
    assign o_sts.r1_zero  = (r_r1 == '0);
    assign o_sts.div_last = (r_cnt == t_cnt'(WIDTH-1));
    assign o_sts.out_busy = r_ovalid && !i_ready;

    assign o_valid         = r_ovalid;
    assign o_divisor       = r_divisor;
    assign o_inverse_value = r_inverse;
    assign o_has_inverse   = r_has_inv;

endmodule

// ===== hdl/modular_inverse_extended_gcd_top.sv =====
// Top level of the modular inverse block: greatest common divisor and inverse of value mod modulus.
// One item is worked on at a time. The value is first reduced modulo the modulus, then quotient
// steps run until the remainder is zero; every division, the initial reduction included, goes
// through one shared restoring divider that yields one quotient bit per cycle, and the quotient
// times the running coefficient is built up alongside it. When the modulus is zero no division runs
// and the value itself is returned as the divisor; a 32-bit operand needs at most 45 quotient steps.
// A finished result waits in an output register, so the next item is taken in while it is still
// unread; the result of that item waits for the register to empty.
module modular_inverse_extended_gcd_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mieg_in_if.sink    i_in,
    mieg_out_if.source o_out
);
    import mieg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mieg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    mieg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_value         (i_in.value),
        .i_modulus       (i_in.modulus),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_divisor       (o_out.divisor),
        .o_inverse_value (o_out.inverse_value),
        .o_has_inverse   (o_out.has_inverse)
    );

endmodule

// ===== hdl/mieg_chk.sv =====
// Port-level checks for the modular inverse block and their binding to the top level.
module mieg_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [mieg_pkg::FIELD_W-1:0] i_divisor,
    input logic [mieg_pkg::FIELD_W-1:0] i_inverse_value,
    input logic                   i_has_inverse
);
    import mieg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_divisor)
            && $stable(i_inverse_value) && $stable(i_has_inverse))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again directly after an item");

    a_inv_gcd_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_inverse |-> i_divisor == FIELD_W'(1))
        else $error("inverse flagged with divisor other than one");

    a_no_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_inverse |-> i_inverse_value == '0)
        else $error("inverse value non-zero without inverse");

endmodule

bind modular_inverse_extended_gcd_top mieg_chk u_mieg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_divisor       (o_out.divisor),
    .i_inverse_value (o_out.inverse_value),
    .i_has_inverse   (o_out.has_inverse)
);

// ===== tb/modular_inverse_extended_gcd_top_tb.sv =====
// Self-checking testbench for the modular inverse block: directed table, then random items.
module modular_inverse_extended_gcd_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mieg_pkg::*;

    localparam int      RANDOM_ITEMS = 1800;
    localparam int      DRAIN_CYCLES = 2000;
    localparam longint  CYCLE_LIMIT  = 20_000_000;
    localparam int      DIR_ROWS     = 24;

    typedef struct packed {
        t_field divisor;
        t_field inverse_value;
        logic   has_inverse;
    } t_inv_result;

    typedef struct packed {
        t_field      value;
        t_field      modulus;
        logic        typed;
        t_inv_result want;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{32'h0,        32'h0,        1'b1, '{32'h0,        32'h0,        1'b0}},
        '{32'hFFFFFFFF, 32'h0,        1'b1, '{32'hFFFFFFFF, 32'h0,        1'b0}},
        '{32'd12345,    32'h0,        1'b1, '{32'd12345,    32'h0,        1'b0}},
        '{32'h0,        32'h1,        1'b1, '{32'h1,        32'h0,        1'b1}},
        '{32'hFFFFFFFF, 32'h1,        1'b1, '{32'h1,        32'h0,        1'b1}},
        '{32'h0,        32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 32'h0,        1'b0}},
        '{32'h0,        32'd7,        1'b1, '{32'd7,        32'h0,        1'b0}},
        '{32'd7,        32'd7,        1'b1, '{32'd7,        32'h0,        1'b0}},
        '{32'd21,       32'd7,        1'b1, '{32'd7,        32'h0,        1'b0}},
        '{32'h1,        32'hFFFFFFFF, 1'b1, '{32'h1,        32'h1,        1'b1}},
        '{32'h1,        32'h2,        1'b1, '{32'h1,        32'h1,        1'b1}},
        '{32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, '{32'h1,        32'hFFFFFFFE, 1'b1}},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, '{32'h1,        32'h1,        1'b1}},
        '{32'hAAAAAAAA, 32'h55555555, 1'b1, '{32'h55555555, 32'h0,        1'b0}},
        '{32'd3,        32'd7,        1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'd10,       32'd3,        1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'd6,        32'd4,        1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'h6D73E55F, 32'hB11924E1, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'h80000000, 32'hFFFFFFFF, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'h55555555, 32'hAAAAAAAA, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'd65537,    32'hFFFFFFFB, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'h2,        32'h80000000, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'hFFFFFFFF, 32'h80000000, 1'b0, '{32'h0,        32'h0,        1'b0}},
        '{32'h12345678, 32'h9ABCDEF1, 1'b0, '{32'h0,        32'h0,        1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    longint      cycle_cnt = 0;
    int          mismatch_cnt = 0;
    bit          no_idle = 1'b0;
    t_inv_result pending_results [$];

    mieg_in_if  in_if ();
    mieg_out_if out_if ();

    modular_inverse_extended_gcd_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_inv_result modinv_predict(input t_field value, input t_field modulus);
        logic [63:0] m, r0, r1, r2, u0, u1, u2, q, mag;
        logic        s0, s1, s2;
        t_inv_result res;
        m   = 64'(t_word'(modulus));
        res = '{divisor: '0, inverse_value: '0, has_inverse: 1'b0};
        if (m == 0) begin
            res.divisor = t_field'(t_word'(value));
        end else begin
            r0 = m;
            r1 = 64'(t_word'(value)) % m;
            u0 = 0;
            u1 = 1;
            s0 = 1'b1;
            s1 = 1'b1;
            while (r1 != 0) begin
                q  = r0 / r1;
                r2 = r0 - q * r1;
                u2 = u0 + q * u1;
                s2 = ~s1;
                r0 = r1; r1 = r2;
                u0 = u1; u1 = u2;
                s0 = s1; s1 = s2;
            end
            res.divisor = t_field'(r0);
            if (r0 == 1) begin
                mag = u0 % m;
                res.has_inverse   = 1'b1;
                res.inverse_value = t_field'(s0 ? mag : (m - mag) % m);
            end
        end
        return res;
    endfunction

    task automatic drive_item(input t_field value, input t_field modulus, input t_inv_result want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.value   <= value;
        in_if.modulus <= modulus;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results.push_back(want);
    endtask

    // hold the sender until every outstanding result has been read
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_result();
        t_inv_result want;
        if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: divisor %0h inverse_value %0h has_inverse %0b",
                   out_if.divisor, out_if.inverse_value, out_if.has_inverse);
            mismatch_cnt++;
        end else begin
            want = pending_results.pop_front();
            if (out_if.divisor !== want.divisor) begin
                $error("divisor: expected %0h, actual %0h", want.divisor, out_if.divisor);
                mismatch_cnt++;
            end
            if (out_if.inverse_value !== want.inverse_value) begin
                $error("inverse_value: expected %0h, actual %0h",
                       want.inverse_value, out_if.inverse_value);
                mismatch_cnt++;
            end
            if (out_if.has_inverse !== want.has_inverse) begin
                $error("has_inverse: expected %0b, actual %0b",
                       want.has_inverse, out_if.has_inverse);
                mismatch_cnt++;
            end
        end
    endtask

    initial begin
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            check_result();
        end
    end

    initial begin
        t_field      value, modulus;
        longint      fib_a, fib_b, fib_t;
        int          sel, k;
        t_inv_result want;

        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.value   <= '0;
        in_if.modulus <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            want = DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want
                 : modinv_predict(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].modulus);
            drive_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].modulus, want);
        end
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = ((i / 150) % 5 == 4);
            if (i == RANDOM_ITEMS / 2)
                hold_until_drained();
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                value   = $urandom;
                modulus = $urandom;
            end else if (sel < 55) begin
                value   = $urandom;
                modulus = $urandom_range(2, 255);
            end else if (sel < 65) begin
                value   = $urandom_range(0, 1000);
                modulus = $urandom_range(0, 1000);
            end else if (sel < 75) begin
                // consecutive Fibonacci numbers: the longest quotient chains
                k     = $urandom_range(1, 46);
                fib_a = 0;
                fib_b = 1;
                repeat (k) begin
                    fib_t = fib_a + fib_b;
                    fib_a = fib_b;
                    fib_b = fib_t;
                end
                if ($urandom_range(0, 3) == 0) begin
                    value   = t_field'(fib_b);
                    modulus = t_field'(fib_a);
                end else begin
                    value   = t_field'(fib_a);
                    modulus = t_field'(fib_b);
                end
            end else if (sel < 82) begin
                modulus = $urandom_range(1, 65535);
                value   = modulus * t_field'($urandom_range(0, 65535));
            end else if (sel < 88) begin
                value   = $urandom;
                modulus = $urandom_range(0, 1);
            end else if (sel < 94) begin
                modulus = $urandom;
                value   = modulus - 1 + t_field'($urandom_range(0, 2));
            end else begin
                value   = $urandom;
                modulus = 32'h1 << $urandom_range(0, 31);
            end
            drive_item(value, modulus, modinv_predict(value, modulus));
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
